FILE: rtl/hrlc_pkg.sv
`timescale 1ns / 1ps

package hrlc_pkg;

  // Depth of the queue between the byte classifier and the parser.
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChSp    = 8'd32;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7a;
  localparam logic [7:0] CaseGap = 8'd32;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_ACCEPT   = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_ERROR    = 3'd3,
    ST_IGNORED  = 3'd4
  } status_e;

  // Field that a byte belongs to.
  typedef enum logic [2:0] {
    TAG_METHOD  = 3'd0,
    TAG_PATH    = 3'd1,
    TAG_VERSION = 3'd2,
    TAG_HEADERS = 3'd3,
    TAG_NONE    = 3'd4
  } field_tag_e;

  typedef enum logic [1:0] {
    MTH_NONE = 2'd0,
    MTH_GET  = 2'd1,
    MTH_POST = 2'd2
  } method_e;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_METHOD  = 6'b000001,
    PH_PATH    = 6'b000010,
    PH_VERSION = 6'b000100,
    PH_HEADERS = 6'b001000,
    PH_DONE    = 6'b010000,
    PH_ERROR   = 6'b100000
  } phase_e;

  // A classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] upper;
    logic       is_cr;
    logic       is_lf;
    logic       is_sp;
    logic       is_dot;
    logic       is_slash;
    logic       start;
  } byte_class_t;

  function automatic logic [7:0] get_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      default: c = 8'h54;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] post_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h50;
      2'd1:    c = 8'h4f;
      2'd2:    c = 8'h53;
      default: c = 8'h54;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] version_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2f;
      3'd5:    c = 8'h31;
      default: c = 8'h2e;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/hrlc_front.sv
`timescale 1ns / 1ps

module hrlc_front
  import hrlc_pkg::*;
(
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_request_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output byte_class_t class_o
);

  logic is_lower;

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // Fold lower-case letters to upper case so that the prefix checks ignore case.
  assign is_lower = (data_byte_i >= ChLowA) && (data_byte_i <= ChLowZ);

  always_comb begin
    class_o.upper    = is_lower ? (data_byte_i - CaseGap) : data_byte_i;
    class_o.is_cr    = data_byte_i == ChCr;
    class_o.is_lf    = data_byte_i == ChLf;
    class_o.is_sp    = data_byte_i == ChSp;
    class_o.is_dot   = data_byte_i == ChDot;
    class_o.is_slash = data_byte_i == ChSlash;
    class_o.start    = start_request_i;
  end

endmodule

FILE: rtl/hrlc_queue.sv
`timescale 1ns / 1ps

module hrlc_queue
  import hrlc_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  byte_class_t wdata_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output byte_class_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  byte_class_t            entries_q [Depth];
  logic        [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic        [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic        [CntW-1:0] count_q, count_d;

  assign full_o  = count_q == FullCnt;
  assign valid_o = count_q != '0;
  assign rdata_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count beyond its depth");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + 1'b1)
    else $error("push without pop did not grow the queue");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

endmodule

FILE: rtl/hrlc_back.sv
`timescale 1ns / 1ps

module hrlc_back
  import hrlc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        entry_valid_i,
  input  byte_class_t entry_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [1:0]  method_code_o,
  output logic [2:0]  field_tag_o
);

  phase_e     phase_q, phase_d, cur_phase;
  logic [2:0] mpos_q, mpos_d, cur_mpos;
  logic       get_ok_q, get_ok_d, cur_get_ok;
  logic       post_ok_q, post_ok_d, cur_post_ok;
  logic       ver_ok_q, ver_ok_d, cur_ver_ok;
  logic [1:0] dd_prog_q, dd_prog_d, cur_dd_prog;
  logic       has_dd_q, has_dd_d, cur_has_dd;
  logic [1:0] le_prog_q, le_prog_d, cur_le_prog;
  method_e    mkind_q, mkind_d, cur_mkind;

  status_e    status_d;
  field_tag_e tag_d;
  logic       line_ok;
  logic [2:0] mpos_bumped;

  logic       out_valid_q;
  status_e    status_q;
  method_e    method_q;
  field_tag_e tag_q;

  // Take the next queued byte whenever the output register is free or being drained.
  assign pop_o = entry_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (entry_i.start) begin
      cur_phase   = PH_METHOD;
      cur_mpos    = '0;
      cur_get_ok  = 1'b1;
      cur_post_ok = 1'b1;
      cur_ver_ok  = 1'b1;
      cur_dd_prog = '0;
      cur_has_dd  = 1'b0;
      cur_le_prog = '0;
      cur_mkind   = MTH_NONE;
    end else begin
      cur_phase   = phase_q;
      cur_mpos    = mpos_q;
      cur_get_ok  = get_ok_q;
      cur_post_ok = post_ok_q;
      cur_ver_ok  = ver_ok_q;
      cur_dd_prog = dd_prog_q;
      cur_has_dd  = has_dd_q;
      cur_le_prog = le_prog_q;
      cur_mkind   = mkind_q;
    end
  end

  assign mpos_bumped = (cur_mpos == 3'd7) ? cur_mpos : cur_mpos + 3'd1;
  assign line_ok = (cur_phase == PH_VERSION) && (cur_mkind != MTH_NONE) && !cur_has_dd &&
                   cur_ver_ok && (cur_mpos == 3'd7);

  always_comb begin
    phase_d   = cur_phase;
    mpos_d    = cur_mpos;
    get_ok_d  = cur_get_ok;
    post_ok_d = cur_post_ok;
    ver_ok_d  = cur_ver_ok;
    dd_prog_d = cur_dd_prog;
    has_dd_d  = cur_has_dd;
    le_prog_d = cur_le_prog;
    mkind_d   = cur_mkind;
    status_d  = ST_BUSY;
    tag_d     = TAG_NONE;
    unique case (cur_phase) inside
      PH_METHOD, PH_PATH, PH_VERSION: begin
        if (entry_i.is_lf && cur_le_prog == 2'd1) begin
          if (line_ok) begin
            status_d  = ST_ACCEPT;
            phase_d   = PH_HEADERS;
            le_prog_d = 2'd2;
          end else begin
            status_d  = ST_ERROR;
            phase_d   = PH_ERROR;
            le_prog_d = 2'd0;
          end
        end else begin
          le_prog_d = entry_i.is_cr ? 2'd1 : 2'd0;
          if (cur_phase == PH_METHOD) begin
            if (entry_i.is_sp) begin
              if (cur_get_ok && cur_mpos >= 3'd3) begin
                mkind_d = MTH_GET;
              end else if (cur_post_ok && cur_mpos >= 3'd4) begin
                mkind_d = MTH_POST;
              end else begin
                mkind_d = MTH_NONE;
              end
              mpos_d  = '0;
              phase_d = PH_PATH;
            end else begin
              tag_d = TAG_METHOD;
              if (cur_mpos < 3'd3 && entry_i.upper != get_char(cur_mpos[1:0])) begin
                get_ok_d = 1'b0;
              end
              if (cur_mpos < 3'd4 && entry_i.upper != post_char(cur_mpos[1:0])) begin
                post_ok_d = 1'b0;
              end
              mpos_d = mpos_bumped;
            end
          end else if (cur_phase == PH_PATH) begin
            if (entry_i.is_sp) begin
              mpos_d  = '0;
              phase_d = PH_VERSION;
            end else begin
              tag_d = TAG_PATH;
              if (entry_i.is_dot) begin
                if (cur_dd_prog < 2'd2) begin
                  dd_prog_d = cur_dd_prog + 2'd1;
                end
              end else begin
                if (entry_i.is_slash && cur_dd_prog == 2'd2) begin
                  has_dd_d = 1'b1;
                end
                dd_prog_d = 2'd0;
              end
            end
          end else begin
            tag_d = TAG_VERSION;
            if (cur_mpos < 3'd7 && entry_i.upper != version_char(cur_mpos)) begin
              ver_ok_d = 1'b0;
            end
            mpos_d = mpos_bumped;
          end
        end
      end
      PH_HEADERS: begin
        tag_d = TAG_HEADERS;
        if (entry_i.is_cr) begin
          le_prog_d = (cur_le_prog == 2'd2) ? 2'd3 : 2'd1;
        end else if (entry_i.is_lf) begin
          if (cur_le_prog == 2'd3) begin
            status_d  = ST_COMPLETE;
            phase_d   = PH_DONE;
            le_prog_d = 2'd0;
          end else if (cur_le_prog == 2'd1) begin
            le_prog_d = 2'd2;
          end else begin
            le_prog_d = 2'd0;
          end
        end else begin
          le_prog_d = 2'd0;
        end
      end
      PH_DONE: begin
        status_d = ST_IGNORED;
      end
      default: begin
        status_d = ST_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_METHOD;
      mpos_q      <= '0;
      get_ok_q    <= 1'b1;
      post_ok_q   <= 1'b1;
      ver_ok_q    <= 1'b1;
      dd_prog_q   <= '0;
      has_dd_q    <= 1'b0;
      le_prog_q   <= '0;
      mkind_q     <= MTH_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q     <= phase_d;
        mpos_q      <= mpos_d;
        get_ok_q    <= get_ok_d;
        post_ok_q   <= post_ok_d;
        ver_ok_q    <= ver_ok_d;
        dd_prog_q   <= dd_prog_d;
        has_dd_q    <= has_dd_d;
        le_prog_q   <= le_prog_d;
        mkind_q     <= mkind_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
      method_q <= mkind_d;
      tag_q    <= tag_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign method_code_o = method_q;
  assign field_tag_o   = tag_q;

  a_pop_fills_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("popped byte produced no result");

  a_accept_untagged : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_ACCEPT |-> tag_q == TAG_NONE && method_q != MTH_NONE)
    else $error("accepted start line with a tag or without a method");

  a_complete_in_headers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_COMPLETE |-> tag_q == TAG_HEADERS)
    else $error("completion outside the header section");

endmodule

FILE: rtl/http_request_line_checker_unit.sv
`timescale 1ns / 1ps

// HTTP request line checker. The unit takes a request one byte per item and returns
// one result item per byte: a status (busy, start line accepted, request complete,
// error, byte ignored), the method recognised so far (GET or POST) and the field the
// byte belongs to. The start line is split at its first two spaces; at its CR LF the
// method must begin with GET or POST, the path must not hold "../" and the version
// must begin with "HTTP/1." (letters compared without regard to case), otherwise the
// unit reports a sticky error until an item arrives with start_request_i set. After
// an accepted line the unit reports completion at the blank line that closes the
// headers. Throughput is one item per clock cycle, sustained while the result side
// does not stall: the front classifier and the back parser each handle one byte a
// cycle, and the parser's state update is a single combinational step. A result
// passes through the queue and then the output register. The queue of QueueDepth
// entries between the two halves absorbs stalls on the result side, so the input
// keeps flowing until the queue fills while a finished result waits to be taken.
module http_request_line_checker_unit
  import hrlc_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       start_request_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [1:0] method_code_o,
  output logic [2:0] field_tag_o
);

  // Classified bytes pass from the front half to the parser through the queue.
  byte_class_t push_class;
  byte_class_t head_class;
  logic        push;
  logic        pop;
  logic        queue_full;
  logic        queue_valid;

  hrlc_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .start_request_i (start_request_i),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .class_o         (push_class)
  );

  hrlc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_class),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .rdata_o (head_class)
  );

  // The parser holds all request state and the output register.
  hrlc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (queue_valid),
    .entry_i       (head_class),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .method_code_o (method_code_o),
    .field_tag_o   (field_tag_o)
  );

endmodule
